// ----- sv/bucket_quartile_digest_coder_macros.svh -----
// assertion helpers shared by the coder modules
`ifndef BUCKET_QUARTILE_DIGEST_CODER_MACROS_SVH
`define BUCKET_QUARTILE_DIGEST_CODER_MACROS_SVH

`ifndef SYNTHESIS

`define BQDC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("bqdc check failed");

`define BQDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bqdc check failed");

`else

`define BQDC_ASSERT_ALWAYS(lbl, expr)

`define BQDC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- sv/bqdc_pkg.sv -----
package bqdc_pkg;

  localparam int BUCKET_COUNT  = 128;
  localparam int COUNT_BITS    = 24;
  localparam int GROUPS        = BUCKET_COUNT / 4;
  localparam int IDX_BITS      = $clog2(BUCKET_COUNT);
  localparam int ROW_BITS      = $clog2(GROUPS);
  localparam int ROW_WIDTH     = 4 * COUNT_BITS;
  localparam int FLUSH_BITS    = $clog2(BUCKET_COUNT + 1);
  localparam int QUO_BITS      = 7;
  localparam int NUM_BITS      = COUNT_BITS + QUO_BITS;
  localparam int STEP_BITS     = $clog2(QUO_BITS);
  localparam int RATIO_SCALE   = 100;
  localparam int TAP_LOW       = (BUCKET_COUNT / 4) - 1;
  localparam int TAP_MID       = (BUCKET_COUNT / 2) - 1;
  localparam int TAP_HIGH      = BUCKET_COUNT - (BUCKET_COUNT / 4) - 1;

  typedef struct packed {
    logic                  valid;
    logic [COUNT_BITS-1:0] value;
  } link_t;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_FLUSH = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_RD    = 6'b001000,
    ST_CAP   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

endpackage

// ----- sv/bqdc_ram.sv -----
module bqdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/bqdc_cell.sv -----
module bqdc_cell
  import bqdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  link_t                 link_in,
  output link_t                 link_out,
  output logic [COUNT_BITS-1:0] held
);

  logic held_valid;

  // keep the smaller value, pass the larger one on
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held_valid     <= 1'b0;
      link_out.valid <= 1'b0;
    end else if (link_in.valid) begin
      if (!held_valid) begin
        held_valid     <= 1'b1;
        held           <= link_in.value;
        link_out.valid <= 1'b0;
      end else if (link_in.value < held) begin
        held           <= link_in.value;
        link_out.value <= held;
        link_out.valid <= 1'b1;
      end else begin
        link_out.value <= link_in.value;
        link_out.valid <= 1'b1;
      end
    end else begin
      link_out.valid <= 1'b0;
    end
  end

endmodule

// ----- sv/bqdc_div.sv -----
`include "bucket_quartile_digest_coder_macros.svh"

module bqdc_div
  import bqdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] num_a,
  input  logic [COUNT_BITS-1:0] num_b,
  input  logic [COUNT_BITS-1:0] den,
  output logic                  done,
  output logic [7:0]            ratio
);

  logic                 busy;
  logic [STEP_BITS-1:0] step;
  logic [NUM_BITS-1:0]  rem_a;
  logic [NUM_BITS-1:0]  rem_b;
  logic [NUM_BITS-1:0]  dsh;
  logic [QUO_BITS-1:0]  quo_a;
  logic [QUO_BITS-1:0]  quo_b;

  // restoring division, one quotient bit per cycle for both ratios
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        step  <= STEP_BITS'(QUO_BITS - 1);
        rem_a <= NUM_BITS'(num_a) * NUM_BITS'(RATIO_SCALE);
        rem_b <= NUM_BITS'(num_b) * NUM_BITS'(RATIO_SCALE);
        dsh   <= NUM_BITS'(den) << (QUO_BITS - 1);
        quo_a <= '0;
        quo_b <= '0;
      end else if (busy) begin
        if (rem_a >= dsh) begin
          rem_a <= rem_a - dsh;
          quo_a <= {quo_a[QUO_BITS-2:0], 1'b1};
        end else begin
          quo_a <= {quo_a[QUO_BITS-2:0], 1'b0};
        end
        if (rem_b >= dsh) begin
          rem_b <= rem_b - dsh;
          quo_b <= {quo_b[QUO_BITS-2:0], 1'b1};
        end else begin
          quo_b <= {quo_b[QUO_BITS-2:0], 1'b0};
        end
        dsh  <= dsh >> 1;
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ratio = {quo_a[3:0], quo_b[3:0]};

  // quartiles are ordered, so both quotients stay within the scale
  `BQDC_ASSERT_ALWAYS(div_range, !done || (quo_a <= QUO_BITS'(RATIO_SCALE) && quo_b <= QUO_BITS'(RATIO_SCALE)))
  `BQDC_ASSERT_NEXT(div_start_idle, start, busy)
  `BQDC_ASSERT_ALWAYS(div_no_overlap, !(start && busy))

endmodule

// ----- sv/bucket_quartile_digest_coder.sv -----
// quartile digest body coder
// input channel: bucket_count with count_valid / count_ready, one count per
// item in bucket order; a run is BUCKET_COUNT items. every count but the last
// gives no result. counts load at one per cycle into a row of sorting cells
// and into a count memory that stores four buckets per row.
// after the last count the block stops taking items: the sorting row drains,
// the three quartiles are read from fixed cells, and the iterative divider
// holds the block while it works out both ratios.
// output channel: code_byte, byte_position, ratio_byte, complete, last_of_run
// with code_valid / code_ready. GROUPS results follow in position order, each
// passing through memory read, code compare and output register, plus any stall.
// a zero third quartile gives a single result with complete low.
// a stalled receiver holds the result register and the whole block; the next
// run starts loading after the last result of a run is taken.
// reset (rst, synchronous) empties the sorting row and returns to loading at
// bucket 0; the count memory needs no clearing.
`include "bucket_quartile_digest_coder_macros.svh"

module bucket_quartile_digest_coder
  import bqdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        count_valid,
  output logic        count_ready,
  input  logic [23:0] bucket_count,
  output logic        code_valid,
  input  logic        code_ready,
  output logic [7:0]  code_byte,
  output logic [4:0]  byte_position,
  output logic [7:0]  ratio_byte,
  output logic        complete,
  output logic        last_of_run
);

  state_t                state;
  logic [IDX_BITS-1:0]   load_index;
  logic [FLUSH_BITS-1:0] flush_cnt;
  logic [ROW_BITS-1:0]   pos;
  logic [COUNT_BITS-1:0] hold [0:2];
  logic [COUNT_BITS-1:0] quartile_low;
  logic [COUNT_BITS-1:0] quartile_mid;
  logic [COUNT_BITS-1:0] quartile_high;
  logic                  div_start;
  logic                  div_done;
  logic [7:0]            div_ratio;
  logic                  accept;
  logic [COUNT_BITS-1:0] count_in;
  logic                  flush_end;
  logic                  ram_we;
  logic [ROW_WIDTH-1:0]  ram_wdata;
  logic [ROW_BITS-1:0]   ram_raddr;
  logic [ROW_WIDTH-1:0]  ram_rdata;
  logic [7:0]            code_calc;
  link_t                 links [0:BUCKET_COUNT-1];
  link_t                 tail_link;
  logic [COUNT_BITS-1:0] held [0:BUCKET_COUNT-1];

  assign count_ready = (state == ST_LOAD);
  assign code_valid  = (state == ST_OUT);
  assign accept      = count_valid && count_ready;
  assign count_in    = COUNT_BITS'(bucket_count);
  assign flush_end   = (state == ST_FLUSH) && (flush_cnt == FLUSH_BITS'(BUCKET_COUNT));

  // sorting row
  assign links[0].valid = accept;
  assign links[0].value = count_in;

  for (genvar i = 0; i < BUCKET_COUNT; i++) begin : g_cell
    if (i < BUCKET_COUNT - 1) begin : g_mid
      bqdc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .clear    (flush_end),
        .link_in  (links[i]),
        .link_out (links[i+1]),
        .held     (held[i])
      );
    end else begin : g_tail
      bqdc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .clear    (flush_end),
        .link_in  (links[i]),
        .link_out (tail_link),
        .held     (held[i])
      );
    end
  end

  // count memory, four buckets per row
  assign ram_we    = accept && (load_index[1:0] == 2'd3);
  assign ram_wdata = {count_in, hold[2], hold[1], hold[0]};
  assign ram_raddr = ROW_BITS'(GROUPS - 1) - pos;

  bqdc_ram #(
    .WIDTH (ROW_WIDTH),
    .DEPTH (GROUPS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_index[IDX_BITS-1:2]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bqdc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_a (quartile_low),
    .num_b (quartile_mid),
    .den   (quartile_high),
    .done  (div_done),
    .ratio (div_ratio)
  );

  always_comb begin
    logic [COUNT_BITS-1:0] k;
    logic [1:0]            c;
    code_calc = '0;
    for (int j = 0; j < 4; j++) begin
      k = ram_rdata[j*COUNT_BITS +: COUNT_BITS];
      if (k > quartile_high) begin
        c = 2'd3;
      end else if (k > quartile_mid) begin
        c = 2'd2;
      end else if (k > quartile_low) begin
        c = 2'd1;
      end else begin
        c = 2'd0;
      end
      code_calc[2*j +: 2] = c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_index <= '0;
      flush_cnt  <= '0;
      pos        <= '0;
      div_start  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (load_index[1:0] != 2'd3) begin
              hold[load_index[1:0]] <= count_in;
            end
            if (load_index == IDX_BITS'(BUCKET_COUNT - 1)) begin
              load_index <= '0;
              flush_cnt  <= '0;
              state      <= ST_FLUSH;
            end else begin
              load_index <= load_index + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          flush_cnt <= flush_cnt + 1'b1;
          if (flush_end) begin
            quartile_low  <= held[TAP_LOW];
            quartile_mid  <= held[TAP_MID];
            quartile_high <= held[TAP_HIGH];
            pos           <= '0;
            if (held[TAP_HIGH] == '0) begin
              code_byte     <= '0;
              byte_position <= '0;
              ratio_byte    <= '0;
              complete      <= 1'b0;
              last_of_run   <= 1'b1;
              state         <= ST_OUT;
            end else begin
              div_start <= 1'b1;
              state     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            ratio_byte <= div_ratio;
            state      <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_CAP;
        end
        ST_CAP: begin
          code_byte     <= code_calc;
          byte_position <= 5'(pos);
          complete      <= 1'b1;
          last_of_run   <= (pos == ROW_BITS'(GROUPS - 1));
          state         <= ST_OUT;
        end
        ST_OUT: begin
          if (code_ready) begin
            if (last_of_run) begin
              state <= ST_LOAD;
            end else begin
              pos   <= pos + 1'b1;
              state <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // a run of exactly BUCKET_COUNT counts never spills past the last cell
  `BQDC_ASSERT_ALWAYS(tail_never_spills, !tail_link.valid)
  `BQDC_ASSERT_ALWAYS(load_or_emit, !(count_ready && code_valid))
  `BQDC_ASSERT_ALWAYS(incomplete_is_last, !code_valid || complete || last_of_run)
  `BQDC_ASSERT_NEXT(run_end_reloads, code_valid && code_ready && last_of_run,
                    count_ready && load_index == '0)

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import bqdc_pkg::*;

  typedef struct {
    logic [7:0] code;
    logic [4:0] pos;
    logic [7:0] ratio;
    logic       comp;
    logic       last;
  } digest_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        count_valid = 1'b0;
  logic        count_ready;
  logic [23:0] bucket_count = '0;
  logic        code_valid;
  logic        code_ready = 1'b0;
  logic [7:0]  code_byte;
  logic [4:0]  byte_position;
  logic [7:0]  ratio_byte;
  logic        complete;
  logic        last_of_run;

  digest_byte_t digest_queue[$];
  logic [COUNT_BITS-1:0] run_counts[BUCKET_COUNT];
  int   fill_index = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  bit   stall_off = 1'b0;

  bucket_quartile_digest_coder DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 50000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // predicts the digest body once the last bucket of a run is loaded
  task automatic predict_digest();
    logic [COUNT_BITS-1:0] sorted[BUCKET_COUNT];
    logic [COUNT_BITS-1:0] q1, q2, q3, k;
    logic [39:0] r1, r2;
    logic [7:0] ratio, code;
    logic [1:0] c;
    digest_byte_t d;
    int g;
    sorted = run_counts;
    sorted.sort();
    q1 = sorted[TAP_LOW];
    q2 = sorted[TAP_MID];
    q3 = sorted[TAP_HIGH];
    if (q3 == 0) begin
      d = '{8'd0, 5'd0, 8'd0, 1'b0, 1'b1};
      digest_queue = {digest_queue, d};
    end else begin
      r1 = ({16'd0, q1} * 40'd100) / q3;
      r2 = ({16'd0, q2} * 40'd100) / q3;
      ratio = {r1[3:0], r2[3:0]};
      for (int p = 0; p < GROUPS; p++) begin
        g = GROUPS - 1 - p;
        code = '0;
        for (int j = 0; j < 4; j++) begin
          k = run_counts[4*g+j];
          if (k > q3) c = 2'd3;
          else if (k > q2) c = 2'd2;
          else if (k > q1) c = 2'd1;
          else c = 2'd0;
          code[2*j +: 2] = c;
        end
        d = '{code, p[4:0], ratio, 1'b1, p == GROUPS - 1};
        digest_queue = {digest_queue, d};
      end
    end
  endtask

  // valid stays high between back to back items
  task automatic send_count(input logic [23:0] value);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap != 0) begin
      count_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    count_valid <= 1'b1;
    bucket_count <= value;
    @(posedge clk);
    while (!count_ready) @(posedge clk);
    run_counts[fill_index] = value[COUNT_BITS-1:0];
    if (fill_index == BUCKET_COUNT - 1) begin
      fill_index = 0;
      predict_digest();
    end else begin
      fill_index++;
    end
  endtask

  function automatic logic [23:0] random_count(input int shape);
    case (shape)
      0: random_count = 24'($urandom_range(0, 3));
      1: random_count = 24'($urandom_range(0, 300));
      default: random_count = 24'($urandom);
    endcase
  endfunction

  task automatic send_run(input int shape);
    for (int i = 0; i < BUCKET_COUNT; i++) send_count(random_count(shape));
  endtask

  task automatic drain_digest();
    @(negedge clk);
    count_valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
  endtask

  // zero third quartile with full scale counts above it
  task automatic test_zero_quartile();
    for (int i = 0; i < BUCKET_COUNT; i++) send_count(i < 97 ? 24'd0 : 24'hffffff);
  endtask

  // full scale descending counts; the receiver does not stall while they load
  task automatic test_full_scale();
    stall_off = 1'b1;
    for (int i = 0; i < BUCKET_COUNT; i++) send_count(24'hffffff - i[23:0]);
    stall_off = 1'b0;
  endtask

  // full drain before the next run starts loading
  task automatic test_drain_pause();
    drain_digest();
    send_run(1);
  endtask

  always @(posedge clk) begin
    digest_byte_t e;
    if (!rst && code_valid && code_ready) begin
      if (digest_queue.size() == 0) begin
        $error("unexpected result, code_byte %0h", code_byte);
        mismatches++;
      end else begin
        e = digest_queue.pop_front();
        if (code_byte !== e.code) begin
          $error("code_byte exp %0h got %0h", e.code, code_byte); mismatches++;
        end
        if (byte_position !== e.pos) begin
          $error("byte_position exp %0d got %0d", e.pos, byte_position); mismatches++;
        end
        if (ratio_byte !== e.ratio) begin
          $error("ratio_byte exp %0h got %0h", e.ratio, ratio_byte); mismatches++;
        end
        if (complete !== e.comp) begin
          $error("complete exp %0b got %0b", e.comp, complete); mismatches++;
        end
        if (last_of_run !== e.last) begin
          $error("last_of_run exp %0b got %0b", e.last, last_of_run); mismatches++;
        end
      end
    end
  end

  // receiver stall drawn per item
  initial begin
    int wait_cycles;
    forever begin
      @(negedge clk);
      code_ready <= 1'b1;
      @(posedge clk);
      while (!code_valid) @(posedge clk);
      wait_cycles = stall_off ? 0 : $urandom_range(0, 12);
      if (wait_cycles != 0) begin
        @(negedge clk);
        code_ready <= 1'b0;
        repeat (wait_cycles - 1) @(negedge clk);
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_zero_quartile();
    test_full_scale();
    test_drain_pause();
    drain_digest();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && digest_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
